// ===== rtl/hrhc_pkg.sv =====
// shared types, constants and keyword tables for the http request header classifier
// no dependencies
`default_nettype none
package hrhc_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 8;
    localparam int NUM_METHODS     = 7;
    localparam int NUM_HEADERS     = 15;
    localparam int POS_BITS        = 5;
    localparam int MAX_NAME        = 19;
    localparam logic [POS_BITS-1:0] POS_MAX = 5'd31;
    localparam logic [2:0] METHOD_UNSUPPORTED = 3'd7;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [1:0] {
        KIND_REQUEST = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_END     = 2'd2
    } line_kind_t;

    localparam logic [1:0] CODE_FIRST = 2'd0;
    localparam logic [1:0] CODE_SECOND = 2'd1;
    localparam logic [1:0] CODE_NONE  = 2'd2;

    // one classified line, handed from the front to the back part
    typedef struct packed {
        line_kind_t  kind;
        logic [3:0]  code;
        logic [1:0]  scheme;
        logic [1:0]  version;
    } line_res_t;

    typedef logic [MAX_NAME*8-1:0] name_t;

    function automatic logic [7:0] name_char(input name_t s, input logic [4:0] len,
                                             input logic [POS_BITS-1:0] pos);
        logic [7:0] c;
        c = 8'h00;
        for (int i = 0; i < MAX_NAME; i++) begin
            if (pos == POS_BITS'(i) && POS_BITS'(i) < len)
                c = s[(int'(len) - 1 - i)*8 +: 8];
        end
        return c;
    endfunction

    function automatic name_t method_name(input int m);
        name_t r;
        r = '0;
        unique case (m)
            0: r = name_t'("OPTIONS");
            1: r = name_t'("HEAD");
            2: r = name_t'("GET");
            3: r = name_t'("POST");
            4: r = name_t'("PUT");
            5: r = name_t'("PATCH");
            default: r = name_t'("DELETE");
        endcase
        return r;
    endfunction

    function automatic logic [4:0] method_len(input int m);
        logic [4:0] r;
        unique case (m)
            0: r = 5'd7;
            1: r = 5'd4;
            2: r = 5'd3;
            3: r = 5'd4;
            4: r = 5'd3;
            5: r = 5'd5;
            default: r = 5'd6;
        endcase
        return r;
    endfunction

    function automatic name_t header_name(input int m);
        name_t r;
        unique case (m)
            0: r = name_t'("Accept");
            1: r = name_t'("Content-Type");
            2: r = name_t'("Content-Length");
            3: r = name_t'("Last-Modified");
            4: r = name_t'("If-Modified-Since");
            5: r = name_t'("If-Unmodified-Since");
            6: r = name_t'("E-Tag");
            7: r = name_t'("If-Match");
            8: r = name_t'("If-None-Match");
            9: r = name_t'("Accept-Patch");
            10: r = name_t'("Location");
            11: r = name_t'("Date");
            12: r = name_t'("Cache-Control");
            13: r = name_t'("Accept-Encoding");
            default: r = name_t'("Last-Event-Id");
        endcase
        return r;
    endfunction

    function automatic logic [4:0] header_len(input int m);
        logic [4:0] r;
        unique case (m)
            0: r = 5'd6;
            1: r = 5'd12;
            2: r = 5'd14;
            3: r = 5'd13;
            4: r = 5'd17;
            5: r = 5'd19;
            6: r = 5'd5;
            7: r = 5'd8;
            8: r = 5'd13;
            9: r = 5'd12;
            10: r = 5'd8;
            11: r = 5'd4;
            12: r = 5'd13;
            13: r = 5'd15;
            default: r = 5'd13;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pattern_char(input int k, input logic [2:0] p);
        logic [7:0] r;
        r = 8'h00;
        unique case (k)
            0: if (p < 3'd5) r = 8'("HTTPS" >> (8 * (4 - int'(p))));
            1: if (p < 3'd4) r = 8'("HTTP" >> (8 * (3 - int'(p))));
            2: if (p < 3'd3) r = 8'("1.1" >> (8 * (2 - int'(p))));
            default: if (p < 3'd3) r = 8'("1.0" >> (8 * (2 - int'(p))));
        endcase
        return r;
    endfunction

    function automatic logic [2:0] pattern_len(input int k);
        logic [2:0] r;
        unique case (k)
            0: r = 3'd5;
            1: r = 3'd4;
            default: r = 3'd3;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/hrhc_front.sv =====
// front part: consumes bytes, tracks line and token state, classifies each line
// depends on hrhc_pkg
`default_nettype none
module hrhc_front
    import hrhc_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire logic [7:0]             data_byte,
    output logic                        emit,
    output line_res_t                   emit_res,
    output logic [OFFSET_BITS-1:0]      emit_offset,
    output logic [COUNT_BITS-1:0]       emit_count
);

    localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;
    localparam logic [COUNT_BITS-1:0]  CNT_MAX = '1;

    logic                   mode_reg, mode_next;
    logic [1:0]             tok_reg, tok_next;
    logic [POS_BITS-1:0]    pos_reg, pos_next;
    logic [NUM_METHODS-1:0] mcand_reg, mcand_next;
    logic [NUM_HEADERS-1:0] hcand_reg, hcand_next;
    logic                   named_reg, named_next;
    logic [11:0]            prog_reg, prog_next;
    logic [3:0]             found_reg, found_next;
    logic [OFFSET_BITS-1:0] ofs_reg, ofs_next;
    logic [OFFSET_BITS-1:0] url_reg, url_next;
    logic [OFFSET_BITS-1:0] val_reg, val_next;
    logic [COUNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                   empty_reg, empty_next;
    logic [2:0]             mheld_reg, mheld_next;

    logic [2:0]             meth_now;
    logic [NUM_HEADERS-1:0] hmatch, hexact;
    logic [NUM_METHODS-1:0] mmatch;
    logic [3:0]             htype;
    logic [COUNT_BITS-1:0]  cnt_inc;
    logic [OFFSET_BITS-1:0] ofs_p1, ofs_p2;
    logic [11:0]            prog_upd;
    logic [3:0]             found_upd;

    always_comb begin
        meth_now = METHOD_UNSUPPORTED;
        for (int m = NUM_METHODS - 1; m >= 0; m--) begin
            if (mcand_reg[m] && method_len(m) == pos_reg)
                meth_now = 3'(m);
        end
        for (int m = 0; m < NUM_METHODS; m++)
            mmatch[m] = mcand_reg[m] && (pos_reg < method_len(m))
                && (name_char(method_name(m), method_len(m), pos_reg) == data_byte);
        for (int m = 0; m < NUM_HEADERS; m++) begin
            hmatch[m] = hcand_reg[m] && (pos_reg < header_len(m))
                && (name_char(header_name(m), header_len(m), pos_reg) == data_byte);
            hexact[m] = hcand_reg[m] && (header_len(m) == pos_reg);
        end
        htype = 4'd0;
        for (int m = NUM_HEADERS - 1; m >= 0; m--) begin
            if (hcand_reg[m])
                htype = 4'(m);
        end
        prog_upd  = prog_reg;
        found_upd = found_reg;
        for (int k = 0; k < 4; k++) begin
            logic [2:0] p;
            p = prog_reg[3*k +: 3];
            if (!found_reg[k]) begin
                if (pattern_char(k, p) == data_byte)
                    p = p + 3'd1;
                else
                    p = (pattern_char(k, 3'd0) == data_byte) ? 3'd1 : 3'd0;
                if (p >= pattern_len(k)) begin
                    found_upd[k] = 1'b1;
                    p = 3'd0;
                end
                prog_upd[3*k +: 3] = p;
            end
        end
    end

    assign cnt_inc = (cnt_reg == CNT_MAX) ? CNT_MAX : cnt_reg + 1'b1;
    assign ofs_p1  = (ofs_reg == OFS_MAX) ? OFS_MAX : ofs_reg + 1'b1;
    assign ofs_p2  = (ofs_reg >= OFS_MAX - 1'b1) ? OFS_MAX : ofs_reg + 2'd2;

    always_comb begin
        mode_next  = mode_reg;
        tok_next   = tok_reg;
        pos_next   = pos_reg;
        mcand_next = mcand_reg;
        hcand_next = hcand_reg;
        named_next = named_reg;
        prog_next  = prog_reg;
        found_next = found_reg;
        ofs_next   = ofs_p1;
        url_next   = url_reg;
        val_next   = val_reg;
        cnt_next   = cnt_reg;
        empty_next = empty_reg;
        mheld_next = mheld_reg;
        emit         = 1'b0;
        emit_res     = '{kind: KIND_REQUEST, code: 4'd0, scheme: CODE_FIRST,
                         version: CODE_FIRST};
        emit_offset  = '0;
        emit_count   = cnt_reg;
        if (data_byte == CH_NL) begin
            pos_next   = '0;
            hcand_next = '1;
            named_next = 1'b0;
            empty_next = 1'b1;
            if (!mode_reg) begin
                emit = 1'b1;
                emit_res.code = {1'b0, (tok_reg == 2'd0) ? meth_now : mheld_reg};
                emit_res.scheme  = found_reg[0] ? CODE_FIRST
                                 : (found_reg[1] ? CODE_SECOND : CODE_NONE);
                emit_res.version = found_reg[2] ? CODE_FIRST
                                 : (found_reg[3] ? CODE_SECOND : CODE_NONE);
                emit_offset = (tok_reg != 2'd0) ? url_reg : '0;
                mode_next = 1'b1;
            end else if (empty_reg) begin
                // blank line closes the request and rearms everything
                emit = 1'b1;
                emit_res.kind = KIND_END;
                mode_next  = 1'b0;
                tok_next   = '0;
                mcand_next = '1;
                prog_next  = '0;
                found_next = '0;
                ofs_next   = '0;
                url_next   = '0;
                val_next   = '0;
                cnt_next   = '0;
                mheld_next = METHOD_UNSUPPORTED;
            end else if (named_reg && hcand_reg != '0) begin
                emit = 1'b1;
                emit_res.kind = KIND_HEADER;
                emit_res.code = htype;
                emit_offset   = val_reg;
                emit_count    = cnt_inc;
                cnt_next      = cnt_inc;
            end
        end else begin
            empty_next = 1'b0;
            if (!mode_reg) begin
                if (data_byte == CH_SPACE) begin
                    if (tok_reg == 2'd0) begin
                        mheld_next = meth_now;
                        url_next   = ofs_p1;
                    end else if (tok_reg == 2'd1) begin
                        prog_next  = '0;
                        found_next = '0;
                    end
                    if (tok_reg != 2'd3)
                        tok_next = tok_reg + 2'd1;
                end else if (tok_reg == 2'd0) begin
                    mcand_next = mmatch;
                    if (pos_reg != POS_MAX)
                        pos_next = pos_reg + 1'b1;
                end else if (tok_reg == 2'd2) begin
                    prog_next  = prog_upd;
                    found_next = found_upd;
                end
            end else if (!named_reg) begin
                if (data_byte == CH_COLON) begin
                    hcand_next = hexact;
                    val_next   = ofs_p2;
                    named_next = 1'b1;
                end else begin
                    hcand_next = hmatch;
                    if (pos_reg != POS_MAX)
                        pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg  <= 1'b0;
            tok_reg   <= '0;
            pos_reg   <= '0;
            mcand_reg <= '1;
            hcand_reg <= '1;
            named_reg <= 1'b0;
            prog_reg  <= '0;
            found_reg <= '0;
            ofs_reg   <= '0;
            url_reg   <= '0;
            val_reg   <= '0;
            cnt_reg   <= '0;
            empty_reg <= 1'b1;
            mheld_reg <= METHOD_UNSUPPORTED;
        end else if (step) begin
            mode_reg  <= mode_next;
            tok_reg   <= tok_next;
            pos_reg   <= pos_next;
            mcand_reg <= mcand_next;
            hcand_reg <= hcand_next;
            named_reg <= named_next;
            prog_reg  <= prog_next;
            found_reg <= found_next;
            ofs_reg   <= ofs_next;
            url_reg   <= url_next;
            val_reg   <= val_next;
            cnt_reg   <= cnt_next;
            empty_reg <= empty_next;
            mheld_reg <= mheld_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/hrhc_queue.sv =====
// two-entry result queue between the front and back parts
// depends on hrhc_pkg
`default_nettype none
module hrhc_queue
    import hrhc_pkg::*;
#(
    parameter int WIDTH = 8
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      head
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wptr_reg, wptr_next;
    logic             rptr_reg, rptr_next;
    logic [1:0]       used_reg, used_next;

    assign full      = used_reg == 2'd2;
    assign not_empty = used_reg != 2'd0;
    assign head      = slot_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ pop;
        used_next = used_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk) begin
        if (push)
            slot_reg[wptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            used_reg <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            used_reg <= used_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/hrhc_back.sv =====
// back part: output register that presents queued results on the output channel
// depends on hrhc_pkg
`default_nettype none
module hrhc_back
    import hrhc_pkg::*;
#(
    parameter int WIDTH = 8
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_not_empty,
    input  wire logic [WIDTH-1:0] q_head,
    output logic                  q_pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    logic             valid_reg, valid_next;
    logic [WIDTH-1:0] data_reg;

    assign q_pop      = q_not_empty && (!valid_reg || out_ready);
    assign valid_next = q_pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk) begin
        if (q_pop)
            data_reg <= q_head;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

endmodule
`default_nettype wire

// ===== rtl/http_request_header_classifier.sv =====
// top level of the http request header classifier
// depends on hrhc_pkg, hrhc_front, hrhc_queue, hrhc_back
`default_nettype none
// Takes one byte of request text per cycle when in_ready is high. Each newline
// closes a line: the request line gives method, scheme, version and URL offset,
// a recognized header gives its type and value offset, a blank line gives the
// header count and rearms for the next request. Classification is done
// combinationally by parallel keyword candidate masks; results go through a
// two-entry queue and an output register, so one byte per cycle is sustained
// and input stalls only when that queue is full, which follows a held output.
module http_request_header_classifier
    import hrhc_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       line_kind,
    output logic [3:0]       kind_code,
    output logic [1:0]       scheme_code,
    output logic [1:0]       version_code,
    output logic [OFFSET_BITS-1:0] field_offset,
    output logic [COUNT_BITS-1:0]  header_count
);

    localparam int RES_W = $bits(line_res_t) + OFFSET_BITS + COUNT_BITS;

    logic                   step, emit, q_full, q_ne, q_pop;
    line_res_t              emit_res, out_res;
    logic [OFFSET_BITS-1:0] emit_offset;
    logic [COUNT_BITS-1:0]  emit_count;
    logic [RES_W-1:0]       q_head, out_data;

    assign in_ready = !q_full;
    assign step     = in_valid && in_ready;

    hrhc_front #(.OFFSET_BITS(OFFSET_BITS), .COUNT_BITS(COUNT_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .step(step), .data_byte(data_byte),
        .emit(emit), .emit_res(emit_res), .emit_offset(emit_offset),
        .emit_count(emit_count)
    );

    hrhc_queue #(.WIDTH(RES_W)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(step && emit),
        .push_data({emit_res, emit_offset, emit_count}), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .head(q_head)
    );

    hrhc_back #(.WIDTH(RES_W)) u_back (
        .clk(clk), .rst_n(rst_n), .q_not_empty(q_ne), .q_head(q_head),
        .q_pop(q_pop), .out_valid(out_valid), .out_ready(out_ready),
        .out_data(out_data)
    );

    assign {out_res, field_offset, header_count} = out_data;
    assign line_kind    = out_res.kind;
    assign kind_code    = out_res.code;
    assign scheme_code  = out_res.scheme;
    assign version_code = out_res.version;

    // no push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_full |-> !(step && emit))
        else $error("push into full queue");
    // pop only when there is a queued result
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_ne)
        else $error("pop from empty queue");
    // a held output result stays unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("output changed while stalled");

endmodule
`default_nettype wire
